/* rtl/nvcp_pkg.sv */
`default_nettype none

package nvcp_pkg;

  // Frame characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Configuration register indexes.
  localparam logic [2:0] REG_NAME_COUNT = 3'd0;
  localparam logic [2:0] REG_NAME_FIRST = 3'd1;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned INDEX_W     = 3;

  // Value format.
  localparam int unsigned FRACTION_DIGITS = 5;
  localparam int unsigned INT_W    = 15;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned FCOUNT_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam logic [INT_W-1:0] INT_MAX = 15'h7FFF;

  // The rounded fraction is floor((f * 2^(17-c) + 5^c) / (2 * 5^c)). The
  // numerator stays below 2^29 and the division is a multiplication by
  // ceil(2^k / (2 * 5^c)) followed by a right shift of k, exact over that range.
  localparam int unsigned NUM_W   = 29;
  localparam int unsigned RECIP_W = 30;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W  = 17;

  function automatic logic [NUM_W-1:0] frac_numerator(logic [FRAC_W-1:0] f,
                                                      logic [FCOUNT_W-1:0] c);
    logic [NUM_W+4:0] wide;
    wide = '0;
    unique case (c)
      3'd1:    wide = ({17'b0, f} << 16) + 34'd5;
      3'd2:    wide = ({17'b0, f} << 15) + 34'd25;
      3'd3:    wide = ({17'b0, f} << 14) + 34'd125;
      3'd4:    wide = ({17'b0, f} << 13) + 34'd625;
      3'd5:    wide = ({17'b0, f} << 12) + 34'd3125;
      default: wide = '0;
    endcase
    return wide[NUM_W-1:0];
  endfunction

  function automatic logic [RECIP_W-1:0] frac_recip(logic [FCOUNT_W-1:0] c);
    logic [RECIP_W-1:0] m;
    unique case (c)
      3'd1:    m = 30'd858993460;
      3'd2:    m = 30'd687194768;
      3'd3:    m = 30'd549755814;
      3'd4:    m = 30'd879609303;
      3'd5:    m = 30'd703687442;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [QUOT_W-1:0] frac_quotient(logic [PROD_W-1:0] p,
                                                      logic [FCOUNT_W-1:0] c);
    logic [QUOT_W-1:0] q;
    unique case (c)
      3'd1:    q = p[33 +: QUOT_W];
      3'd2:    q = p[35 +: QUOT_W];
      3'd3:    q = p[37 +: QUOT_W];
      3'd4:    q = p[40 +: QUOT_W];
      3'd5:    q = p[42 +: QUOT_W];
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

/* rtl/name_value_command_parser_top.sv */
`default_nettype none
// A result beat passes the frame snapshot, name compare, fraction multiply and output
// registers in that order after the final byte of a frame is accepted.
// Throughput: one byte per cycle while results are taken, a frame can end in every
// cycle; the 30 x 29 bit fraction multiplier is fully pipelined, so nothing iterates.
// Reset (rst_ni low, asynchronous): frame state, held value, configuration registers and
// all valid flags are cleared; the block is ready for bytes as soon as it is released.

module name_value_command_parser_top
  import nvcp_pkg::*;
#(
  parameter int unsigned NAME_BYTES = 8,
  parameter int unsigned MAX_NAMES  = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port.
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Byte stream in.
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [7:0]             s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic                   s_axis_tlast_i,   // last_byte
  // Result stream out.
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [VALUE_W-1:0]          m_axis_tdata_o,   // [31:0] value
  output logic [INDEX_W:0]            m_axis_tuser_o    // [0] matched, [3:1] name_index
);

  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned LEN_W  = $clog2(NAME_BYTES + 1);

  typedef enum logic [1:0] {
    PH_NAME,
    PH_VSTART,
    PH_VDIGITS,
    PH_VDONE
  } phase_e;

  // Snapshot of a finished frame.
  typedef struct packed {
    logic                ok;
    logic [NAME_W-1:0]   name;
    logic                neg;
    logic [INT_W-1:0]    int_part;
    logic [FRAC_W-1:0]   frac;
    logic [FCOUNT_W-1:0] fcount;
  } snap_t;

  // After the name compare.
  typedef struct packed {
    logic                hit;
    logic [INDEX_W-1:0]  idx;
    logic                neg;
    logic [INT_W-1:0]    int_part;
    logic [NUM_W-1:0]    num;
    logic [RECIP_W-1:0]  recip;
    logic [FCOUNT_W-1:0] fcount;
  } cmp_t;

  // After the fraction multiply.
  typedef struct packed {
    logic                hit;
    logic [INDEX_W-1:0]  idx;
    logic                neg;
    logic [INT_W-1:0]    int_part;
    logic [PROD_W-1:0]   prod;
    logic [FCOUNT_W-1:0] fcount;
  } mul_t;

  // Configuration registers.
  logic [COUNT_W-1:0]    name_count_q;
  logic [CFG_DATA_W-1:0] names_q [MAX_NAMES];

  // Frame state.
  phase_e              phase_q, phase_d;
  logic [NAME_W-1:0]   name_q, name_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                bad_q, bad_d;
  logic                neg_q, neg_d;
  logic [INT_W-1:0]    int_q, int_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [FCOUNT_W-1:0] fcount_q, fcount_d;
  logic                infrac_q, infrac_d;

  // Pipeline.
  logic                snap_v_q, cmp_v_q, mul_v_q, out_v_q;
  snap_t               snap_q, snap_d;
  cmp_t                cmp_q, cmp_d;
  mul_t                mul_q, mul_d;
  logic                out_hit_q;
  logic [INDEX_W-1:0]  out_idx_q;
  logic [VALUE_W-1:0]  out_value_q, value_d;
  logic [VALUE_W-1:0]  held_q, held_d;

  logic                out_rdy, mul_rdy, cmp_rdy, snap_rdy;
  logic                in_beat, frame_end;

  // Each stage moves on when it is empty or its successor takes its contents.
  assign out_rdy  = !out_v_q  || m_axis_tready_i;
  assign mul_rdy  = !mul_v_q  || out_rdy;
  assign cmp_rdy  = !cmp_v_q  || mul_rdy;
  assign snap_rdy = !snap_v_q || cmp_rdy;

  assign s_axis_tready_o = snap_rdy;
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign frame_end = in_beat && s_axis_tlast_i;

  // ---------------------------------------------------------------------------
  // Per-byte update of the frame state.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  b;
    logic        vbyte;
    logic [3:0]  digit;
    logic [18:0] int_next;
    b        = s_axis_tdata_i;
    vbyte    = 1'b0;
    digit    = b[3:0];
    int_next = {4'b0, int_q} * 19'd10 + {15'b0, digit};

    phase_d  = phase_q;
    name_d   = name_q;
    len_d    = len_q;
    bad_d    = bad_q;
    neg_d    = neg_q;
    int_d    = int_q;
    frac_d   = frac_q;
    fcount_d = fcount_q;
    infrac_d = infrac_q;

    unique case (phase_q)
      PH_NAME: begin
        if (!bad_q) begin
          if (b == CH_EQ) begin
            phase_d = PH_VSTART;
          end else if (b == CH_NUL) begin
            bad_d = 1'b1;
          end else if (len_q < LEN_W'(NAME_BYTES)) begin
            for (int i = 0; i < NAME_BYTES; i++) begin
              if (len_q == LEN_W'(i)) begin
                name_d[8*i +: 8] = b;
              end
            end
            len_d = len_q + 1'b1;
          end
        end
      end
      PH_VSTART: begin
        phase_d = PH_VDIGITS;
        if (b == CH_MINUS) begin
          neg_d = 1'b1;
        end else if (b != CH_PLUS) begin
          vbyte = 1'b1;
        end
      end
      PH_VDIGITS: vbyte = 1'b1;
      default: ;
    endcase

    // Value characters: a dot switches to the fraction once, anything that is
    // neither a dot nor a digit ends the value ('#' and NUL among them).
    if (vbyte) begin
      if (b == CH_DOT) begin
        infrac_d = 1'b1;
      end else if (b < CH_ZERO || b > CH_NINE) begin
        phase_d = PH_VDONE;
      end else if (!infrac_q) begin
        int_d = (int_next > 19'(INT_MAX)) ? INT_MAX : int_next[INT_W-1:0];
      end else if (fcount_q < FCOUNT_W'(FRACTION_DIGITS)) begin
        frac_d   = frac_q * FRAC_W'(10) + {13'b0, digit};
        fcount_d = fcount_q + 1'b1;
      end
    end
  end

  always_comb begin
    snap_d.ok       = (phase_d != PH_NAME) && !bad_d;
    snap_d.name     = name_d;
    snap_d.neg      = neg_d;
    snap_d.int_part = int_d;
    snap_d.frac     = frac_d;
    snap_d.fcount   = fcount_d;
  end

  // ---------------------------------------------------------------------------
  // Name compare and fraction numerator. The lowest matching index wins.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [COUNT_W-1:0]    n_eff;
    logic [CFG_DATA_W-1:0] name_wide;
    n_eff = (name_count_q > COUNT_W'(MAX_NAMES)) ? COUNT_W'(MAX_NAMES) : name_count_q;
    name_wide = CFG_DATA_W'(snap_q.name);
    cmp_d.hit = 1'b0;
    cmp_d.idx = '0;
    for (int k = MAX_NAMES - 1; k >= 0; k--) begin
      if (snap_q.ok && (COUNT_W'(k) < n_eff) && (names_q[k] == name_wide)) begin
        cmp_d.hit = 1'b1;
        cmp_d.idx = INDEX_W'(k);
      end
    end
    cmp_d.neg      = snap_q.neg;
    cmp_d.int_part = snap_q.int_part;
    cmp_d.num      = frac_numerator(snap_q.frac, snap_q.fcount);
    cmp_d.recip    = frac_recip(snap_q.fcount);
    cmp_d.fcount   = snap_q.fcount;
  end

  always_comb begin
    mul_d.hit      = cmp_q.hit;
    mul_d.idx      = cmp_q.idx;
    mul_d.neg      = cmp_q.neg;
    mul_d.int_part = cmp_q.int_part;
    mul_d.prod     = PROD_W'(cmp_q.num) * PROD_W'(cmp_q.recip);
    mul_d.fcount   = cmp_q.fcount;
  end

  // ---------------------------------------------------------------------------
  // Q16.16 assembly: the fraction is capped at all ones, then the sign applied.
  // An unmatched frame reports the last matched value.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [QUOT_W-1:0]  q;
    logic [15:0]        fr;
    logic [VALUE_W-1:0] mag;
    q   = frac_quotient(mul_q.prod, mul_q.fcount);
    fr  = q[QUOT_W-1] ? 16'hFFFF : q[15:0];
    mag = {1'b0, mul_q.int_part, fr};
    held_d  = mul_q.hit ? (mul_q.neg ? (~mag + 1'b1) : mag) : held_q;
    value_d = held_d;
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_count_q <= '0;
      for (int k = 0; k < MAX_NAMES; k++) begin
        names_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_NAME_COUNT) begin
        name_count_q <= cfg_wdata_i[COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_NAMES; k++) begin
        if (cfg_index_i == REG_NAME_FIRST + CFG_INDEX_W'(k)) begin
          names_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NAME;
      name_q   <= '0;
      len_q    <= '0;
      bad_q    <= 1'b0;
      neg_q    <= 1'b0;
      int_q    <= '0;
      frac_q   <= '0;
      fcount_q <= '0;
      infrac_q <= 1'b0;
    end else if (frame_end) begin
      phase_q  <= PH_NAME;
      name_q   <= '0;
      len_q    <= '0;
      bad_q    <= 1'b0;
      neg_q    <= 1'b0;
      int_q    <= '0;
      frac_q   <= '0;
      fcount_q <= '0;
      infrac_q <= 1'b0;
    end else if (in_beat) begin
      phase_q  <= phase_d;
      name_q   <= name_d;
      len_q    <= len_d;
      bad_q    <= bad_d;
      neg_q    <= neg_d;
      int_q    <= int_d;
      frac_q   <= frac_d;
      fcount_q <= fcount_d;
      infrac_q <= infrac_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
      cmp_v_q  <= 1'b0;
      mul_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      held_q   <= '0;
    end else begin
      if (snap_rdy) snap_v_q <= frame_end;
      if (cmp_rdy)  cmp_v_q  <= snap_v_q;
      if (mul_rdy)  mul_v_q  <= cmp_v_q;
      if (out_rdy) begin
        out_v_q <= mul_v_q;
        if (mul_v_q) held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_rdy) snap_q <= snap_d;
    if (cmp_rdy)  cmp_q  <= cmp_d;
    if (mul_rdy)  mul_q  <= mul_d;
    if (out_rdy && mul_v_q) begin
      out_hit_q   <= mul_q.hit;
      out_idx_q   <= mul_q.idx;
      out_value_q <= value_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_idx_q, out_hit_q};

`ifndef SYNTHESIS
  // Input can only be held off by a result waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // An unmatched result always carries index zero.
  a_unmatched_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tuser_o[INDEX_W:1] == '0))
    else $error("unmatched result with nonzero index");

  // Every result shows the held value, which it has just set when matched.
  a_value_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o == held_q))
    else $error("result value differs from held value");

  // A frame boundary moves a beat into the pipeline in the next cycle.
  a_frame_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> snap_v_q)
    else $error("final byte produced no pipeline entry");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

// Self-checking bench for the name=value command parser.
//
// Bytes go in as beats on the slave stream, one frame at a time, with tlast on
// the final byte. A behavioural model of the parser below follows every
// accepted beat. When a frame closes, the report it should produce is queued.
// Reports coming out of the master stream are compared field by field with
// the oldest queued entry.
//
// The run has two parts. First comes a short directed table of frames. It
// covers reset state, integer saturation, the empty name, a lone sign, a NUL
// inside the name, an overlong name, a frame with no '=' and trailing bytes
// after the terminator. After that, random frames run under a series of name
// tables. Both stream sides idle at random.

module testbench;
  import nvcp_pkg::*;

  localparam int unsigned NAME_SLOTS    = 6;
  localparam int unsigned NAME_CHARS    = 8;
  localparam int unsigned BYTE_TARGET   = 1550;
  localparam int unsigned RECONFIG_STEP = 200;
  // Allow generous slack after the last report before touching the registers
  // or ending the run.
  localparam int unsigned SETTLE_CYCLES = 8;
  // A correct run never goes this long without a beat on either side. The
  // worst case is a sender gap or a chain of receiver stalls, a settle wait
  // and eight register writes.
  localparam int unsigned STALL_LIMIT   = 4000;
  // Index 7 lies beyond the register list; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = REG_NAME_FIRST + 3'd6;

  typedef enum logic [1:0] {SCAN_NAME, SCAN_SIGN, SCAN_DIGITS, SCAN_DONE} scan_e;

  typedef struct packed {
    logic               matched;
    logic [INDEX_W-1:0] name_index;
    logic [VALUE_W-1:0] value;
  } report_t;

  // One directed frame: text right-aligned, first character highest.
  typedef struct packed {
    logic [127:0] text;
    logic [4:0]   len;
    logic         typed;
    report_t      want;
  } frame_row_t;

  logic                   clk_i;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic [7:0]             in_byte   = '0;
  logic                   in_last   = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [VALUE_W-1:0]     out_value;
  logic [INDEX_W:0]       out_flags;

  // Mirror of the configuration registers.
  logic [COUNT_W-1:0]     cfg_name_count;
  logic [CFG_DATA_W-1:0]  cfg_names    [NAME_SLOTS];
  logic [CFG_DATA_W-1:0]  staged_names [NAME_SLOTS];

  // Frame state of the behavioural parser.
  scan_e                  scan;
  logic [63:0]            frame_name;
  int unsigned            frame_name_len;
  bit                     name_void;
  bit                     minus;
  bit                     after_dot;
  int unsigned            whole;
  int unsigned            frac;
  int unsigned            frac_digits;
  logic [VALUE_W-1:0]     held;

  report_t                pending_reports [$];
  logic [7:0]             frame_bytes [$];
  int unsigned            failures     = 0;
  int unsigned            bytes_sent   = 0;
  int unsigned            quiet_cycles = 0;
  bit                     steady_tx    = 0;

  name_value_command_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),     // [7:0] byte_value
    .s_axis_tlast_i  (in_last),     // last_byte
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_value),   // [31:0] value
    .m_axis_tuser_o  (out_flags)    // [0] matched, [3:1] name_index
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 48);
  endfunction

  // Name characters are mostly capitals, with the odd arbitrary non-zero byte.
  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [63:0] random_name();
    logic [63:0] n;
    int unsigned len;
    int unsigned style;
    int unsigned i;
    n = '0;
    style = $urandom_range(0, 19);
    if (style == 0) return '0;    // empty name
    if (style == 1) return '1;    // eight 0xFF characters
    len = $urandom_range(1, NAME_CHARS);
    for (i = 0; i < len; i++) n[8*i +: 8] = name_char();
    // A zero byte with characters after it makes a name that can never match.
    if (style == 2 && len > 1) n[8*$urandom_range(0, len - 2) +: 8] = CH_NUL;
    return n;
  endfunction

  task automatic restart_frame();
    scan           = SCAN_NAME;
    frame_name     = '0;
    frame_name_len = 0;
    name_void      = 0;
    minus          = 0;
    after_dot      = 0;
    whole          = 0;
    frac           = 0;
    frac_digits    = 0;
  endtask

  // A value character: digit, dot, or anything else, which ends the value.
  task automatic take_value_char(input logic [7:0] b);
    if (b == CH_DOT) begin
      after_dot = 1;
    end else if (b < CH_ZERO || b > CH_NINE) begin
      scan = SCAN_DONE;
    end else if (!after_dot) begin
      whole = whole * 10 + (b - CH_ZERO);
      if (whole > int'(INT_MAX)) whole = int'(INT_MAX);
    end else if (frac_digits < FRACTION_DIGITS) begin
      frac = frac * 10 + (b - CH_ZERO);
      frac_digits++;
    end
  endtask

  // Advances the model by one byte. On the final byte of a frame it gives
  // the report that the block must send.
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit fired, output report_t rep);
    int unsigned        lim;
    int unsigned        k;
    longint unsigned    den;
    longint unsigned    fr;
    logic [VALUE_W-1:0] mag;
    fired = 0;
    rep   = '0;
    case (scan)
      SCAN_NAME: begin
        if (!name_void) begin
          if (b == CH_EQ) begin
            scan = SCAN_SIGN;
          end else if (b == CH_NUL) begin
            name_void = 1;
          end else if (frame_name_len < NAME_CHARS) begin
            frame_name[8*frame_name_len +: 8] = b;
            frame_name_len++;
          end
        end
      end
      SCAN_SIGN: begin
        scan = SCAN_DIGITS;
        if (b == CH_MINUS) minus = 1;
        else if (b != CH_PLUS) take_value_char(b);
      end
      SCAN_DIGITS: take_value_char(b);
      default: ;
    endcase
    if (last) begin
      fired = 1;
      if (scan != SCAN_NAME && !name_void) begin
        lim = cfg_name_count > NAME_SLOTS ? NAME_SLOTS : cfg_name_count;
        for (k = 0; k < lim; k++) begin
          if (!rep.matched && cfg_names[k] == frame_name) begin
            rep.matched    = 1'b1;
            rep.name_index = 3'(k);
          end
        end
      end
      if (rep.matched) begin
        // Fraction bits: round to nearest, ties up, capped at 16 bits.
        den = 1;
        repeat (frac_digits) den = den * 10;
        fr = frac;
        fr = (fr * 65536 + den / 2) / den;
        if (fr > 65535) fr = 65535;
        mag  = {1'b0, whole[14:0], fr[15:0]};
        held = minus ? -mag : mag;
      end
      rep.value = held;
      restart_frame();
    end
  endtask

  // Offers one byte, waits for the handshake, then feeds the model. A typed
  // expectation, where given, replaces the modelled one.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit use_typed, input report_t typed_rep);
    int unsigned gap;
    bit          fired;
    report_t     rep;
    gap = steady_tx ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk_i); while (!in_ready);
    parse_byte(b, last, fired, rep);
    if (fired) pending_reports.push_back(use_typed ? typed_rep : rep);
    bytes_sent++;
  endtask

  // Brings the block to rest: no byte offered, every report in, pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (idx == REG_NAME_COUNT) cfg_name_count = data[COUNT_W-1:0];
    else if (idx <= REG_NAME_FIRST + NAME_SLOTS - 1) cfg_names[idx - REG_NAME_FIRST] = data;
  endtask

  // Writes the staged names, the count, and junk to the unused index.
  task automatic load_config(input logic [COUNT_W-1:0] count);
    int unsigned k;
    for (k = 0; k < NAME_SLOTS; k++) write_reg(REG_NAME_FIRST + 3'(k), staged_names[k]);
    write_reg(REG_NAME_COUNT, count);
    write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    frame_row_t         directed_rows [8];
    frame_row_t         row;
    logic [63:0]        word;
    logic [COUNT_W-1:0] count;
    int unsigned        r;
    int unsigned        i;
    int unsigned        shape;
    int unsigned        pick;
    int unsigned        phase;
    int unsigned        next_reconfig;

    cfg_name_count = '0;
    foreach (cfg_names[k]) cfg_names[k] = '0;
    held = '0;
    restart_frame();

    // The first row runs on the reset configuration. The rest run with
    // K at slot 0, the empty name at slot 1, an eight-character name at
    // slot 2, a broken name at slot 3, all ones at slot 4 and a second K
    // at slot 5. The count is written as 7 and must be clipped to 6.
    directed_rows = '{
      '{"=",            5'd1,  1'b1, '{1'b0, 3'd0, 32'h0000_0000}},
      // The integer part saturates.
      '{"K=40000",      5'd7,  1'b1, '{1'b1, 3'd0, 32'h7FFF_0000}},
      // The empty name hits slot 1; the second dot is skipped.
      '{"=-1..5",       5'd6,  1'b1, '{1'b1, 3'd1, 32'hFFFE_8000}},
      // NUL before '=': no match, the last value is held.
      '{{"K", CH_NUL, "="}, 5'd3, 1'b1, '{1'b0, 3'd0, 32'hFFFE_8000}},
      // The ninth name character is dropped before the compare.
      '{"ABCDEFGHI=.5", 5'd12, 1'b0, '{1'b0, 3'd0, 32'h0000_0000}},
      // A sign and nothing else.
      '{"K=-",          5'd3,  1'b1, '{1'b1, 3'd0, 32'h0000_0000}},
      // No '=' at all.
      '{"K",            5'd1,  1'b1, '{1'b0, 3'd0, 32'h0000_0000}},
      // '=' then the terminator, then a stray byte.
      '{"=#x",          5'd3,  1'b1, '{1'b1, 3'd1, 32'h0000_0000}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < 8; r++) begin
      if (r == 1) begin
        settle();
        staged_names[0] = 64'h4B;                   // "K"
        staged_names[1] = 64'h0;                    // empty
        staged_names[2] = 64'h4847_4645_4443_4241;  // "ABCDEFGH"
        staged_names[3] = 64'h42_0041;              // 'A', NUL, 'B'
        staged_names[4] = '1;
        staged_names[5] = 64'h4B;                   // "K" again, slot 0 must win
        load_config(3'd7);
      end
      row       = directed_rows[r];
      steady_tx = ($urandom_range(0, 2) == 0);
      for (i = 0; i < row.len; i++)
        send_byte(row.text[8*(row.len - 1 - i) +: 8], i == row.len - 1, row.typed, row.want);
    end

    // Random frames. The name table changes every few hundred bytes. The
    // first changes use a full, an overfull, an empty and a single-entry
    // table.
    phase         = 0;
    next_reconfig = bytes_sent;
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= next_reconfig) begin
        settle();
        case (phase)
          0:       count = 3'd6;
          1:       count = 3'd7;
          2:       count = 3'd0;
          3:       count = 3'd1;
          default: count = 3'($urandom_range(0, 7));
        endcase
        foreach (staged_names[k]) staged_names[k] = random_name();
        if ($urandom_range(0, 1) == 0) staged_names[$urandom_range(1, 5)] = staged_names[0];
        load_config(count);
        phase++;
        next_reconfig = bytes_sent + RECONFIG_STEP;
      end

      frame_bytes.delete();
      steady_tx = ($urandom_range(0, 3) == 0);
      shape     = $urandom_range(0, 99);
      if (shape < 15) begin
        // Noise: arbitrary bytes of any value.
        repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Most names come from the table, some get extra characters so that
        // they overrun eight or no longer match, the rest are made up.
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          word = cfg_names[$urandom_range(0, NAME_SLOTS - 1)];
          for (i = 0; i < NAME_CHARS && word[8*i +: 8] != CH_NUL; i++)
            frame_bytes.push_back(word[8*i +: 8]);
          if (pick == 6) repeat ($urandom_range(1, 3)) frame_bytes.push_back(name_char());
        end else begin
          repeat ($urandom_range(0, 10)) frame_bytes.push_back(name_char());
        end
        if (shape < 22) frame_bytes.insert($urandom_range(0, frame_bytes.size()), CH_NUL);
        if (shape >= 27) begin
          frame_bytes.push_back(CH_EQ);
          case ($urandom_range(0, 3))
            0:       frame_bytes.push_back(CH_MINUS);
            1:       frame_bytes.push_back(CH_PLUS);
            default: ;
          endcase
          repeat ($urandom_range(0, 6))
            frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 2) != 0) begin
            frame_bytes.push_back(CH_DOT);
            repeat ($urandom_range(0, 8)) begin
              if ($urandom_range(0, 15) == 0) frame_bytes.push_back(CH_DOT);
              frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
          end
          case ($urandom_range(0, 4))
            0:       ;  // the frame ends on the value itself
            1:       frame_bytes.push_back(CH_NUL);
            2:       frame_bytes.push_back(8'($urandom_range(0, 255)));
            default: frame_bytes.push_back(CH_HASH);
          endcase
          // Bytes after the terminator are ignored by the block.
          repeat ($urandom_range(0, 2) * $urandom_range(0, 2))
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (frame_bytes.size() == 0) frame_bytes.push_back(CH_EQ);
      foreach (frame_bytes[j])
        send_byte(frame_bytes[j], j == frame_bytes.size() - 1, 1'b0, '0);
    end

    settle();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The receiver holds tready high or low for runs of random length, so that
  // stalls land on every stage of the result pipeline.
  initial begin : drain_side
    int unsigned run;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run != 0) begin
        run--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        run = pick_gap();
      end else begin
        out_ready <= 1'b1;
        run = $urandom_range(1, 40);
      end
    end
  end

  // Every report beat is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report beat with nothing expected: matched %0d index %0d value %h",
               out_flags[0], out_flags[INDEX_W:1], out_value);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        if (out_flags[0] !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, out_flags[0]);
          failures++;
        end
        if (out_flags[INDEX_W:1] !== want.name_index) begin
          $error("name_index: expected %0d, got %0d", want.name_index, out_flags[INDEX_W:1]);
          failures++;
        end
        if (out_value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_value);
          failures++;
        end
      end
    end
  end

  // Ends a run that has hung: too long without a beat on either stream.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
